// ----- hdl/icrd_pkg.sv -----
// Shared types, codes and constants for the icon channel RLE decoder.
`timescale 1ns / 1ps
package icrd_pkg;

    localparam int MAX_PIXELS_DEF = 16384;
    localparam int CFG_PIX_W      = 15;
    localparam int Q_DEPTH        = 4;

    localparam logic [7:0] RUN_BIAS     = 8'd125;
    localparam logic [2:0] PREFIX_BYTES = 3'd4;
    localparam logic [1:0] CH_DONE      = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EARLY    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_PIXEL_COUNT = 1'b0;
    localparam logic REG_SKIP_PREFIX = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_REPVAL  = 2'd1,
        PH_LITERAL = 2'd2
    } t_phase;

    // one classified input byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       start;
        logic       run;
        logic [7:0] count;
    } t_token;

    // skip_prefix write event toward the decoder
    typedef struct packed {
        logic skip_wr;
        logic skip;
    } t_cfg_ev;

endpackage

// ----- hdl/icon_channel_rle_decoder_unit.sv -----
// An accepted byte enters the token queue; the decoder step on it loads the output register.
// Throughput: one compressed byte per cycle while the queue and the output do not stall.
// A four-entry queue lets input acceptance and result delivery stall independently.
// Reset (synchronous, active low) restores pixel_count 16384, skip_prefix 0 and clears
// decoder state and queue at once; there is no clearing pass.
`timescale 1ns / 1ps
module icon_channel_rle_decoder_unit #(
    parameter int MAX_PIXELS = icrd_pkg::MAX_PIXELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // compressed byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // last_byte
    input  logic [0:0]  s_axis_tuser,   // [0] start_image
    // decoded run writes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [1:0] channel, [15:2] start_position,
                                        // [23:16] run_length, [31:24] pixel_value
    output logic        m_axis_tlast,   // image_done
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import icrd_pkg::*;

    localparam int PW = $clog2(MAX_PIXELS + 1);
    localparam int CW = (PW > CFG_PIX_W) ? PW : CFG_PIX_W;

    logic [CFG_PIX_W-1:0] r_pixel_count;
    logic                 r_skip_prefix;
    logic [PW-1:0]        r_plane_size;
    logic [CW-1:0]        w_pc;
    logic [CW-1:0]        w_cap;
    logic [PW-1:0]        n_plane_size;
    logic                 w_wr;
    t_cfg_ev              w_cfg_ev;

    logic                 w_push;
    logic                 w_pop;
    logic                 w_full;
    logic                 w_empty;
    t_token               w_in_token;
    t_token               w_q_token;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= CFG_PIX_W'(16384);
            r_skip_prefix <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_PIXEL_COUNT: r_pixel_count <= pwdata[CFG_PIX_W-1:0];
                REG_SKIP_PREFIX: r_skip_prefix <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PIXEL_COUNT: prdata = 32'(r_pixel_count);
            REG_SKIP_PREFIX: prdata = 32'(r_skip_prefix);
            default:         prdata = '0;
        endcase
    end

    assign w_cfg_ev.skip_wr = w_wr && (paddr[2] == REG_SKIP_PREFIX);
    assign w_cfg_ev.skip    = pwdata[0];

    // plane size clamped to 1..MAX_PIXELS, registered off the decode path
    assign w_pc  = CW'(r_pixel_count);
    assign w_cap = CW'(MAX_PIXELS);
    always_comb begin
        if (w_pc == '0) begin
            n_plane_size = PW'(1);
        end else if (w_pc > w_cap) begin
            n_plane_size = PW'(w_cap);
        end else begin
            n_plane_size = PW'(w_pc);
        end
    end

    always_ff @(posedge i_clk) begin
        r_plane_size <= n_plane_size;
    end

    icrd_front u_front (
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .i_s_tuser  (s_axis_tuser[0]),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_token    (w_in_token)
    );

    icrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_in_token),
        .i_pop   (w_pop),
        .o_token (w_q_token),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    icrd_back #(
        .MAX_PIXELS (MAX_PIXELS),
        .PW         (PW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_plane_size  (r_plane_size),
        .i_skip_prefix (r_skip_prefix),
        .i_cfg_ev      (w_cfg_ev),
        .i_q_empty     (w_empty),
        .i_token       (w_q_token),
        .o_pop         (w_pop),
        .o_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tlast     (m_axis_tlast),
        .o_m_tuser     (m_axis_tuser)
    );

endmodule

// ----- hdl/icrd_front.sv -----
// Input side: accepts compressed bytes and precomputes the run header count.
`timescale 1ns / 1ps
module icrd_front (
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [7:0]      i_s_tdata,
    input  logic            i_s_tlast,
    input  logic            i_s_tuser,
    input  logic            i_q_full,
    output logic            o_push,
    output icrd_pkg::t_token o_token
);
    import icrd_pkg::*;

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

    // header classification is speculative: the back end uses it only in header phase
    always_comb begin
        o_token.data  = i_s_tdata;
        o_token.last  = i_s_tlast;
        o_token.start = i_s_tuser;
        o_token.run   = i_s_tdata[7];
        if (i_s_tdata[7]) begin
            o_token.count = i_s_tdata - RUN_BIAS;
        end else begin
            o_token.count = i_s_tdata + 8'd1;
        end
    end

endmodule

// ----- hdl/icrd_queue.sv -----
// Short token queue between the front end and the decoder.
`timescale 1ns / 1ps
module icrd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  icrd_pkg::t_token i_token,
    input  logic             i_pop,
    output icrd_pkg::t_token o_token,
    output logic             o_full,
    output logic             o_empty
);
    import icrd_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_token             r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_token = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue pushed while full");

endmodule

// ----- hdl/icrd_back.sv -----
// Decoder back end: run-length state, plane tracking and the result register.
`timescale 1ns / 1ps
module icrd_back #(
    parameter int MAX_PIXELS = icrd_pkg::MAX_PIXELS_DEF,
    parameter int PW         = $clog2(MAX_PIXELS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PW-1:0]     i_plane_size,
    input  logic              i_skip_prefix,
    input  icrd_pkg::t_cfg_ev i_cfg_ev,
    input  logic              i_q_empty,
    input  icrd_pkg::t_token  i_token,
    output logic              o_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [31:0]       o_m_tdata,
    output logic              o_m_tlast,
    output logic [1:0]        o_m_tuser
);
    import icrd_pkg::*;

    localparam int LW = (PW > 8) ? PW : 8;

    t_phase         r_phase, n_phase;
    logic [7:0]     r_lit, n_lit;
    logic [PW-1:0]  r_pos, n_pos;
    logic [1:0]     r_ch, n_ch;
    logic [2:0]     r_prefix, n_prefix;
    logic           r_halted, n_halted;
    logic           r_fresh, n_fresh;

    logic           r_out_valid;
    logic [31:0]    r_out_data, n_out_data;
    logic           r_out_last;
    logic [1:0]     r_out_user;

    t_phase         e_phase;
    logic [7:0]     e_lit;
    logic [PW-1:0]  e_pos;
    logic [1:0]     e_ch;
    logic [2:0]     e_prefix;
    logic           e_halted;

    logic [PW-1:0]  w_rem;
    logic           w_emit;
    logic           w_wrote;
    logic [7:0]     w_len;
    logic [7:0]     w_val;
    logic [1:0]     w_st;
    logic           w_done;
    logic           w_step;

    assign w_step = !i_q_empty && (!r_out_valid || i_m_tready);
    assign o_pop  = w_step;

    // start_image clears the decoder before the byte is handled
    always_comb begin
        if (i_token.start) begin
            e_phase  = PH_HEADER;
            e_lit    = '0;
            e_pos    = '0;
            e_ch     = '0;
            e_prefix = i_skip_prefix ? PREFIX_BYTES : 3'd0;
            e_halted = 1'b0;
        end else begin
            e_phase  = r_phase;
            e_lit    = r_lit;
            e_pos    = r_pos;
            e_ch     = r_ch;
            e_prefix = r_prefix;
            e_halted = r_halted;
        end
    end

    assign w_rem = (e_pos < i_plane_size) ? (i_plane_size - e_pos) : '0;

    // next state of the decoder for the token at the queue head
    always_comb begin
        n_phase  = e_phase;
        n_lit    = e_lit;
        n_pos    = e_pos;
        n_ch     = e_ch;
        n_prefix = e_prefix;
        n_halted = e_halted;
        n_fresh  = i_token.start ? 1'b1 : r_fresh;
        w_emit   = 1'b0;
        w_wrote  = 1'b0;
        w_len    = '0;
        w_val    = '0;
        w_st     = ST_OK;
        w_done   = 1'b0;

        if (!e_halted && e_ch != CH_DONE) begin
            n_fresh = 1'b0;
            if (e_prefix != '0) begin
                n_prefix = e_prefix - 3'd1;
            end else begin
                unique case (e_phase)
                    PH_REPVAL: begin
                        w_emit = 1'b1;
                        w_val  = i_token.data;
                        if (LW'(e_lit) > LW'(w_rem)) begin
                            w_len = 8'(w_rem);
                            w_st  = ST_OVERFLOW;
                        end else begin
                            w_len = e_lit;
                        end
                        n_pos   = e_pos + PW'(w_len);
                        n_lit   = '0;
                        n_phase = PH_HEADER;
                        w_wrote = 1'b1;
                    end
                    PH_LITERAL: begin
                        w_emit = 1'b1;
                        w_val  = i_token.data;
                        if (e_pos < i_plane_size) begin
                            w_len = 8'd1;
                            n_pos = e_pos + PW'(1);
                            n_lit = (e_lit != '0) ? e_lit - 8'd1 : e_lit;
                            if (n_lit == '0) begin
                                n_phase = PH_HEADER;
                            end
                            w_wrote = 1'b1;
                        end else begin
                            w_st = ST_OVERFLOW;
                        end
                    end
                    default: begin
                        n_lit   = i_token.count;
                        n_phase = i_token.run ? PH_REPVAL : PH_LITERAL;
                    end
                endcase
            end

            if (w_wrote && w_st == ST_OK && n_pos >= i_plane_size) begin
                if (n_phase == PH_LITERAL) begin
                    // plane full with literal bytes still pending
                    w_st = i_token.last ? ST_EARLY : ST_OVERFLOW;
                end else begin
                    n_ch   = e_ch + 2'd1;
                    n_pos  = '0;
                    w_done = (n_ch == CH_DONE);
                end
            end

            if (w_st == ST_OK && i_token.last && !w_done) begin
                w_st = ST_EARLY;
            end
            if (w_st != ST_OK) begin
                n_halted = 1'b1;
                w_emit   = 1'b1;
            end
        end
    end

    // result payload: channel, start position, run length, pixel value
    always_comb begin
        n_out_data = {w_val, w_len, 14'(e_pos), e_ch};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_lit    <= '0;
            r_pos    <= '0;
            r_ch     <= '0;
            r_prefix <= '0;
            r_halted <= 1'b0;
            r_fresh  <= 1'b1;
        end else if (w_step) begin
            r_phase  <= n_phase;
            r_lit    <= n_lit;
            r_pos    <= n_pos;
            r_ch     <= n_ch;
            r_prefix <= n_prefix;
            r_halted <= n_halted;
            r_fresh  <= n_fresh;
        end else if (i_cfg_ev.skip_wr && r_fresh) begin
            r_prefix <= i_cfg_ev.skip ? PREFIX_BYTES : 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= n_out_data;
            r_out_last <= w_done;
            r_out_user <= w_st;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_st != ST_OK) |=> r_halted)
        else $error("error status without halt");

    a_done_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ch == CH_DONE) |-> (r_pos == '0))
        else $error("image done with nonzero position");

    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_user == ST_OK))
        else $error("image done flagged with error status");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && e_halted) |-> !w_emit)
        else $error("result produced while halted");

endmodule
